### hw/rtl/tda_pkg.sv
// ----------------------------------------------------------------------------
// tda_pkg
// Types, opcodes, constants and time-field helpers for the time-of-day unit.
// ----------------------------------------------------------------------------
`default_nettype none

package tda_pkg;

    localparam logic [3:0] OP_VALIDATE = 4'd0;
    localparam logic [3:0] OP_NEXT_SEC = 4'd1;
    localparam logic [3:0] OP_PREV_SEC = 4'd2;
    localparam logic [3:0] OP_ADD      = 4'd3;
    localparam logic [3:0] OP_DIFF     = 4'd4;
    localparam logic [3:0] OP_COMPARE  = 4'd5;
    localparam logic [3:0] OP_DURATION = 4'd6;
    localparam logic [3:0] OP_TO_SECS  = 4'd7;
    localparam logic [3:0] OP_FROM_SECS = 4'd8;
    localparam logic [3:0] OP_ADD_N    = 4'd9;
    localparam logic [3:0] OP_SUB_N    = 4'd10;

    localparam logic [1:0] ORDER_LESS    = 2'd0;
    localparam logic [1:0] ORDER_EQUAL   = 2'd1;
    localparam logic [1:0] ORDER_GREATER = 2'd2;

    localparam logic [16:0] DAY_SECS  = 17'd86400;
    localparam logic [5:0]  MAX_HOUR  = 6'd23;
    localparam logic [5:0]  MAX_MS    = 6'd59;
    localparam logic [6:0]  HOURS_DAY = 7'd24;
    localparam logic [6:0]  MS_BASE   = 7'd60;

    // floor(n / 3600) == (n * HOUR_RECIP) >> HOUR_SHIFT for n < 86400
    localparam logic [17:0] HOUR_RECIP = 18'd149131;
    localparam int unsigned HOUR_SHIFT = 29;
    // floor(r / 60) == (r * MIN_RECIP) >> MIN_SHIFT for r < 3600
    localparam logic [12:0] MIN_RECIP  = 13'd4370;
    localparam int unsigned MIN_SHIFT  = 18;

    typedef struct packed {
        logic [5:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
    } hms_t;

    typedef struct packed {
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
    } tod_t;

    typedef struct packed {
        logic [3:0]  opcode;
        hms_t        a;
        hms_t        b;
        logic [16:0] ta;
        logic [16:0] tb;
        logic        a_ok;
        logic        b_ok;
        logic        n_ok;
    } item_t;

    function automatic logic time_ok(hms_t t);
        return (t.hour <= MAX_HOUR) && (t.minute <= MAX_MS) && (t.second <= MAX_MS);
    endfunction

    function automatic logic [16:0] to_secs(hms_t t);
        logic [17:0] sum;
        sum = 18'(t.hour) * 18'd3600 + 18'(t.minute) * 18'd60 + 18'(t.second);
        return sum[16:0];
    endfunction

    // mixed-radix add, both operands in range
    function automatic tod_t hms_add(hms_t x, hms_t y);
        logic [6:0] s_sum;
        logic [6:0] m_sum;
        logic [6:0] h_sum;
        logic       s_carry;
        logic       m_carry;
        tod_t       r;
        s_sum   = {1'b0, x.second} + {1'b0, y.second};
        s_carry = (s_sum >= MS_BASE);
        if (s_carry)
        begin
            s_sum = s_sum - MS_BASE;
        end
        m_sum   = {1'b0, x.minute} + {1'b0, y.minute} + {6'd0, s_carry};
        m_carry = (m_sum >= MS_BASE);
        if (m_carry)
        begin
            m_sum = m_sum - MS_BASE;
        end
        h_sum = {1'b0, x.hour} + {1'b0, y.hour} + {6'd0, m_carry};
        if (h_sum >= HOURS_DAY)
        begin
            h_sum = h_sum - HOURS_DAY;
        end
        r.second = s_sum[5:0];
        r.minute = m_sum[5:0];
        r.hour   = h_sum[4:0];
        return r;
    endfunction

    // mixed-radix x - y with wrap past midnight, both operands in range
    function automatic tod_t hms_sub(hms_t x, hms_t y);
        logic [6:0] s_dif;
        logic [6:0] m_dif;
        logic [6:0] h_dif;
        logic       s_borrow;
        logic       m_borrow;
        tod_t       r;
        s_dif    = {1'b0, x.second} - {1'b0, y.second};
        s_borrow = s_dif[6];
        if (s_borrow)
        begin
            s_dif = s_dif + MS_BASE;
        end
        m_dif    = {1'b0, x.minute} - {1'b0, y.minute} - {6'd0, s_borrow};
        m_borrow = m_dif[6];
        if (m_borrow)
        begin
            m_dif = m_dif + MS_BASE;
        end
        h_dif = {1'b0, x.hour} - {1'b0, y.hour} - {6'd0, m_borrow};
        if (h_dif[6])
        begin
            h_dif = h_dif + HOURS_DAY;
        end
        r.second = s_dif[5:0];
        r.minute = m_dif[5:0];
        r.hour   = h_dif[4:0];
        return r;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/tda_n_split.sv
// ----------------------------------------------------------------------------
// tda_n_split
// Three-stage pipeline that splits a second count into hour, minute, second
// by reciprocal multiplication.
// ----------------------------------------------------------------------------
`default_nettype none

module tda_n_split
(
    input  wire logic          clk,
    input  wire logic [16:0]   n,
    output tda_pkg::tod_t      nt
);

    logic [34:0] hour_prod;
    logic [4:0]  hour_a_next;
    logic [4:0]  hour_a_reg;
    logic [16:0] n_a_reg;

    logic [16:0] rem_full;
    logic [11:0] rem_b_next;
    logic [24:0] min_prod;
    logic [5:0]  min_b_next;
    logic [11:0] rem_b_reg;
    logic [5:0]  min_b_reg;
    logic [4:0]  hour_b_reg;

    logic [11:0] sec_full;
    tda_pkg::tod_t nt_next;
    tda_pkg::tod_t nt_reg;

    // stage a: hour quotient
    assign hour_prod   = 35'(n) * 35'(tda_pkg::HOUR_RECIP);
    assign hour_a_next = hour_prod[tda_pkg::HOUR_SHIFT +: 5];

    // stage b: remainder within the hour and minute quotient
    assign rem_full   = n_a_reg - 17'(hour_a_reg) * 17'd3600;
    assign rem_b_next = rem_full[11:0];
    assign min_prod   = 25'(rem_b_next) * 25'(tda_pkg::MIN_RECIP);
    assign min_b_next = min_prod[tda_pkg::MIN_SHIFT +: 6];

    // stage c: seconds left over
    assign sec_full       = rem_b_reg - 12'(min_b_reg) * 12'd60;
    assign nt_next.hour   = hour_b_reg;
    assign nt_next.minute = min_b_reg;
    assign nt_next.second = sec_full[5:0];

    always_ff @(posedge clk)
    begin
        hour_a_reg <= hour_a_next;
        n_a_reg    <= n;
        rem_b_reg  <= rem_b_next;
        min_b_reg  <= min_b_next;
        hour_b_reg <= hour_a_reg;
        nt_reg     <= nt_next;
    end

    assign nt = nt_reg;

endmodule

`default_nettype wire

### hw/rtl/tda_alu.sv
// ----------------------------------------------------------------------------
// tda_alu
// Operand checks, mixed-radix add and subtract, compare and second counts,
// with the result register and done strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module tda_alu
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    input  wire tda_pkg::item_t       item,
    input  wire tda_pkg::tod_t        nt,
    output logic                      done,
    output logic        [4:0]         res_hour,
    output logic        [5:0]         res_minute,
    output logic        [5:0]         res_second,
    output logic signed [17:0]        seconds_value,
    output logic        [1:0]         order,
    output logic                      invalid
);

    tda_pkg::hms_t one_sec;
    tda_pkg::hms_t n_hms;
    tda_pkg::hms_t add_y;
    tda_pkg::hms_t sub_x;
    tda_pkg::hms_t sub_y;
    tda_pkg::tod_t sum_t;
    tda_pkg::tod_t dif_t;
    logic          bad;
    logic [17:0]   dur;

    tda_pkg::tod_t time_next;
    logic [17:0]   secs_next;
    logic [1:0]    order_next;
    logic          invalid_next;

    logic          done_reg;
    tda_pkg::tod_t time_reg;
    logic [17:0]   secs_reg;
    logic [1:0]    order_reg;
    logic          invalid_reg;

    assign one_sec = '{hour: 6'd0, minute: 6'd0, second: 6'd1};
    assign n_hms   = '{hour: {1'b0, nt.hour}, minute: nt.minute, second: nt.second};
    assign dur     = {1'b0, item.tb} - {1'b0, item.ta};

    always_comb
    begin
        case (item.opcode)
            tda_pkg::OP_VALIDATE,
            tda_pkg::OP_NEXT_SEC,
            tda_pkg::OP_PREV_SEC,
            tda_pkg::OP_TO_SECS:   bad = !item.a_ok;
            tda_pkg::OP_ADD,
            tda_pkg::OP_DIFF,
            tda_pkg::OP_COMPARE,
            tda_pkg::OP_DURATION:  bad = !(item.a_ok && item.b_ok);
            tda_pkg::OP_FROM_SECS: bad = !item.n_ok;
            tda_pkg::OP_ADD_N,
            tda_pkg::OP_SUB_N:     bad = !(item.a_ok && item.n_ok);
            default:               bad = 1'b1;
        endcase
    end

    // one shared mixed-radix adder and one shared mixed-radix subtractor
    always_comb
    begin
        case (item.opcode)
            tda_pkg::OP_NEXT_SEC: add_y = one_sec;
            tda_pkg::OP_ADD:      add_y = item.b;
            default:              add_y = n_hms;
        endcase
        case (item.opcode)
            tda_pkg::OP_PREV_SEC:
            begin
                sub_x = item.a;
                sub_y = one_sec;
            end
            tda_pkg::OP_DIFF:
            begin
                sub_x = item.b;
                sub_y = item.a;
            end
            default:
            begin
                sub_x = item.a;
                sub_y = n_hms;
            end
        endcase
    end

    assign sum_t = tda_pkg::hms_add(item.a, add_y);
    assign dif_t = tda_pkg::hms_sub(sub_x, sub_y);

    always_comb
    begin
        time_next    = '0;
        secs_next    = '0;
        order_next   = tda_pkg::ORDER_LESS;
        invalid_next = bad;
        if (!bad)
        begin
            case (item.opcode)
                tda_pkg::OP_NEXT_SEC,
                tda_pkg::OP_ADD,
                tda_pkg::OP_ADD_N:     time_next = sum_t;
                tda_pkg::OP_PREV_SEC,
                tda_pkg::OP_DIFF,
                tda_pkg::OP_SUB_N:     time_next = dif_t;
                tda_pkg::OP_FROM_SECS: time_next = nt;
                tda_pkg::OP_COMPARE:
                begin
                    if (item.ta < item.tb)
                    begin
                        order_next = tda_pkg::ORDER_LESS;
                    end
                    else if (item.ta == item.tb)
                    begin
                        order_next = tda_pkg::ORDER_EQUAL;
                    end
                    else
                    begin
                        order_next = tda_pkg::ORDER_GREATER;
                    end
                end
                tda_pkg::OP_DURATION:  secs_next = dur;
                tda_pkg::OP_TO_SECS:   secs_next = {1'b0, item.ta};
                default:               time_next = '0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        time_reg    <= time_next;
        secs_reg    <= secs_next;
        order_reg   <= order_next;
        invalid_reg <= invalid_next;
    end

    assign done          = done_reg;
    assign res_hour      = time_reg.hour;
    assign res_minute    = time_reg.minute;
    assign res_second    = time_reg.second;
    assign seconds_value = $signed(secs_reg);
    assign order         = order_reg;
    assign invalid       = invalid_reg;

endmodule

`default_nettype wire

### hw/rtl/time_of_day_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// time_of_day_arithmetic_unit
// Stateless hour:minute:second arithmetic with 24-hour wrap.
// ----------------------------------------------------------------------------
// One item is taken in every clock cycle: busy is always low, and each beat
// accepted with start gives exactly one result, marked by done. Each item
// passes the input register, the three-stage split of n_seconds into hour,
// minute and second (two reciprocal multiplies in turn), and the result
// register. Results come in the order items went in, one per cycle, and must
// be taken in the cycle done is high.
`default_nettype none

module time_of_day_arithmetic_unit
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic        [3:0]  opcode,
    input  wire logic        [5:0]  a_hour,
    input  wire logic        [5:0]  a_minute,
    input  wire logic        [5:0]  a_second,
    input  wire logic        [5:0]  b_hour,
    input  wire logic        [5:0]  b_minute,
    input  wire logic        [5:0]  b_second,
    input  wire logic        [16:0] n_seconds,
    output logic                    done,
    output logic             [4:0]  res_hour,
    output logic             [5:0]  res_minute,
    output logic             [5:0]  res_second,
    output logic signed      [17:0] seconds_value,
    output logic             [1:0]  order,
    output logic                    invalid
);

    logic           valid_s1_reg;
    logic           valid_s2_reg;
    logic           valid_s3_reg;
    logic           valid_s4_reg;
    logic           accept;

    logic [3:0]     op_s1_reg;
    tda_pkg::hms_t  a_s1_reg;
    tda_pkg::hms_t  b_s1_reg;
    logic [16:0]    n_s1_reg;

    tda_pkg::item_t item_s2_next;
    tda_pkg::item_t item_s2_reg;
    tda_pkg::item_t item_s3_reg;
    tda_pkg::item_t item_s4_reg;
    tda_pkg::tod_t  nt_s4;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_s1_reg <= 1'b0;
            valid_s2_reg <= 1'b0;
            valid_s3_reg <= 1'b0;
            valid_s4_reg <= 1'b0;
        end
        else
        begin
            valid_s1_reg <= accept;
            valid_s2_reg <= valid_s1_reg;
            valid_s3_reg <= valid_s2_reg;
            valid_s4_reg <= valid_s3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        op_s1_reg <= opcode;
        a_s1_reg  <= '{hour: a_hour, minute: a_minute, second: a_second};
        b_s1_reg  <= '{hour: b_hour, minute: b_minute, second: b_second};
        n_s1_reg  <= n_seconds;
    end

    // range checks and second counts, then carried along beside the n split
    always_comb
    begin
        item_s2_next.opcode = op_s1_reg;
        item_s2_next.a      = a_s1_reg;
        item_s2_next.b      = b_s1_reg;
        item_s2_next.ta     = tda_pkg::to_secs(a_s1_reg);
        item_s2_next.tb     = tda_pkg::to_secs(b_s1_reg);
        item_s2_next.a_ok   = tda_pkg::time_ok(a_s1_reg);
        item_s2_next.b_ok   = tda_pkg::time_ok(b_s1_reg);
        item_s2_next.n_ok   = (n_s1_reg < tda_pkg::DAY_SECS);
    end

    always_ff @(posedge clk)
    begin
        item_s2_reg <= item_s2_next;
        item_s3_reg <= item_s2_reg;
        item_s4_reg <= item_s3_reg;
    end

    tda_n_split u_n_split
    (
        .clk (clk),
        .n   (n_s1_reg),
        .nt  (nt_s4)
    );

    tda_alu u_alu
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (valid_s4_reg),
        .item          (item_s4_reg),
        .nt            (nt_s4),
        .done          (done),
        .res_hour      (res_hour),
        .res_minute    (res_minute),
        .res_second    (res_second),
        .seconds_value (seconds_value),
        .order         (order),
        .invalid       (invalid)
    );

endmodule

`default_nettype wire

### tb/sv/time_of_day_arithmetic_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// time_of_day_arithmetic_unit_test
// Self-checking bench for the hour:minute:second arithmetic unit.
// ----------------------------------------------------------------------------
// Corner cases come first, then random traffic with mostly in-range times and
// some out-of-range operands and unused opcodes, under three sender gap
// patterns. Every accepted beat is predicted here and each done strobe is
// compared field by field with the oldest pending prediction.
// ----------------------------------------------------------------------------

module time_of_day_arithmetic_unit_test;

    localparam int CLK_HALF      = 4;
    localparam int RESET_CYCLES  = 12;
    localparam int CYCLE_LIMIT   = 100000;
    localparam int DRAIN_CYCLES  = 12;
    localparam int RANDOM_ITEMS  = 430;
    localparam int DAY_LEN       = 86400;
    localparam int N_LAST_VALID  = 86399;
    localparam int N_FIELD_MAX   = 131071;

    localparam logic [3:0] OP_FIRST_UNUSED = 4'd11;
    localparam logic [3:0] OP_LAST_UNUSED  = 4'd15;

    typedef struct packed {
        tda_pkg::tod_t      tm;
        logic signed [17:0] secs;
        logic [1:0]         order;
        logic               invalid;
    } tod_result_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic        [3:0]  opcode;
    logic        [5:0]  a_hour;
    logic        [5:0]  a_minute;
    logic        [5:0]  a_second;
    logic        [5:0]  b_hour;
    logic        [5:0]  b_minute;
    logic        [5:0]  b_second;
    logic        [16:0] n_seconds;
    logic               done;
    logic        [4:0]  res_hour;
    logic        [5:0]  res_minute;
    logic        [5:0]  res_second;
    logic signed [17:0] seconds_value;
    logic        [1:0]  order;
    logic               invalid;

    tod_result_t expected_results[$];
    tod_result_t oldest_result;
    int          error_count;
    int          items_sent;
    int          results_checked;
    int          cycle_count;
    int          idle_pct;

    time_of_day_arithmetic_unit dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .opcode        (opcode),
        .a_hour        (a_hour),
        .a_minute      (a_minute),
        .a_second      (a_second),
        .b_hour        (b_hour),
        .b_minute      (b_minute),
        .b_second      (b_second),
        .n_seconds     (n_seconds),
        .done          (done),
        .res_hour      (res_hour),
        .res_minute    (res_minute),
        .res_second    (res_second),
        .seconds_value (seconds_value),
        .order         (order),
        .invalid       (invalid)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #CLK_HALF clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycle_count, expected_results.size());
            $display("time_of_day_arithmetic_unit: mismatch");
            $finish;
        end
    end

    function automatic tda_pkg::hms_t make_time(int h, int m, int s);
        tda_pkg::hms_t t;
        t.hour   = 6'(h);
        t.minute = 6'(m);
        t.second = 6'(s);
        return t;
    endfunction

    function automatic int day_seconds(tda_pkg::hms_t t);
        return int'(t.hour) * 3600 + int'(t.minute) * 60 + int'(t.second);
    endfunction

    function automatic logic in_range(tda_pkg::hms_t t);
        return (t.hour <= 23) && (t.minute <= 59) && (t.second <= 59);
    endfunction

    function automatic tda_pkg::tod_t split_day(int total);
        tda_pkg::tod_t r;
        int            t;
        t        = total % DAY_LEN;
        r.hour   = 5'(t / 3600);
        r.minute = 6'((t % 3600) / 60);
        r.second = 6'(t % 60);
        return r;
    endfunction

    function automatic tod_result_t predict_tod(logic [3:0] op, tda_pkg::hms_t a,
                                                tda_pkg::hms_t b, logic [16:0] n);
        tod_result_t r;
        logic        a_ok;
        logic        b_ok;
        logic        n_ok;
        logic        bad;
        int          ta;
        int          tb;
        int          nv;
        r    = '0;
        a_ok = in_range(a);
        b_ok = in_range(b);
        nv   = int'(n);
        n_ok = (nv < DAY_LEN);
        ta   = day_seconds(a);
        tb   = day_seconds(b);
        case (op)
            tda_pkg::OP_VALIDATE, tda_pkg::OP_NEXT_SEC,
            tda_pkg::OP_PREV_SEC, tda_pkg::OP_TO_SECS:  bad = !a_ok;
            tda_pkg::OP_ADD, tda_pkg::OP_DIFF,
            tda_pkg::OP_COMPARE, tda_pkg::OP_DURATION: bad = !(a_ok && b_ok);
            tda_pkg::OP_FROM_SECS:                     bad = !n_ok;
            tda_pkg::OP_ADD_N, tda_pkg::OP_SUB_N:      bad = !(a_ok && n_ok);
            default:                                   bad = 1'b1;
        endcase
        if (bad)
        begin
            r.invalid = 1'b1;
            return r;
        end
        case (op)
            tda_pkg::OP_NEXT_SEC:  r.tm = split_day(ta + 1);
            tda_pkg::OP_PREV_SEC:  r.tm = split_day(ta + DAY_LEN - 1);
            tda_pkg::OP_ADD:       r.tm = split_day(ta + tb);
            tda_pkg::OP_DIFF:      r.tm = split_day(tb + DAY_LEN - ta);
            tda_pkg::OP_COMPARE:
            begin
                if (ta < tb)
                begin
                    r.order = tda_pkg::ORDER_LESS;
                end
                else if (ta == tb)
                begin
                    r.order = tda_pkg::ORDER_EQUAL;
                end
                else
                begin
                    r.order = tda_pkg::ORDER_GREATER;
                end
            end
            tda_pkg::OP_DURATION:  r.secs = 18'(tb - ta);
            tda_pkg::OP_TO_SECS:   r.secs = 18'(ta);
            tda_pkg::OP_FROM_SECS: r.tm = split_day(nv);
            tda_pkg::OP_ADD_N:     r.tm = split_day(ta + nv);
            tda_pkg::OP_SUB_N:     r.tm = split_day(ta + DAY_LEN - nv);
            default:               r = r;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        error_count++;
        $display("[%0t] %s", $realtime, msg);
    endtask

    // results are sampled at the edge that ends their cycle
    always @(posedge clk)
    begin
        if (done === 1'b1)
        begin
            if (expected_results.size() == 0)
            begin
                report_mismatch("result strobe with no item pending");
            end
            else
            begin
                oldest_result = expected_results.pop_front();
                results_checked++;
                if (res_hour !== oldest_result.tm.hour)
                    report_mismatch($sformatf("res_hour got %0d expected %0d",
                                              res_hour, oldest_result.tm.hour));
                if (res_minute !== oldest_result.tm.minute)
                    report_mismatch($sformatf("res_minute got %0d expected %0d",
                                              res_minute, oldest_result.tm.minute));
                if (res_second !== oldest_result.tm.second)
                    report_mismatch($sformatf("res_second got %0d expected %0d",
                                              res_second, oldest_result.tm.second));
                if (seconds_value !== oldest_result.secs)
                    report_mismatch($sformatf("seconds_value got %0d expected %0d",
                                              seconds_value, oldest_result.secs));
                if (order !== oldest_result.order)
                    report_mismatch($sformatf("order got %0d expected %0d",
                                              order, oldest_result.order));
                if (invalid !== oldest_result.invalid)
                    report_mismatch($sformatf("invalid got %0d expected %0d",
                                              invalid, oldest_result.invalid));
            end
        end
    end

    // called at a rising edge; returns at the edge that takes the beat
    task automatic send_item(logic [3:0] op, tda_pkg::hms_t a, tda_pkg::hms_t b,
                             logic [16:0] n);
        // each cycle is idle with probability idle_pct percent
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        opcode    <= op;
        a_hour    <= a.hour;
        a_minute  <= a.minute;
        a_second  <= a.second;
        b_hour    <= b.hour;
        b_minute  <= b.minute;
        b_second  <= b.second;
        n_seconds <= n;
        start     <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (busy !== 1'b0);
        expected_results.push_back(predict_tod(op, a, b, n));
        items_sent++;
    endtask

    function automatic tda_pkg::hms_t pick_time(logic legal);
        tda_pkg::hms_t t;
        case ($urandom_range(9))
            0:       t = make_time(0, 0, 0);
            1:       t = make_time(23, 59, 59);
            default: t = make_time($urandom_range(23), $urandom_range(59),
                                   $urandom_range(59));
        endcase
        if (!legal)
        begin
            case ($urandom_range(3))
                0:       t.hour   = 6'($urandom_range(24, 63));
                1:       t.minute = 6'($urandom_range(60, 63));
                2:       t.second = 6'($urandom_range(60, 63));
                default: t = make_time($urandom_range(63), $urandom_range(63),
                                       $urandom_range(63));
            endcase
        end
        return t;
    endfunction

    function automatic logic [16:0] pick_count();
        case ($urandom_range(19))
            0:       return 17'd0;
            1:       return 17'(N_LAST_VALID);
            2, 3:    return 17'($urandom_range(DAY_LEN, N_FIELD_MAX));
            default: return 17'($urandom_range(0, N_LAST_VALID));
        endcase
    endfunction

    task automatic run_random_items(int count);
        logic [3:0] op;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(99) < 8)
                op = 4'($urandom_range(OP_FIRST_UNUSED, OP_LAST_UNUSED));
            else
                op = 4'($urandom_range(tda_pkg::OP_VALIDATE, tda_pkg::OP_SUB_N));
            send_item(op, pick_time($urandom_range(99) < 85),
                      pick_time($urandom_range(99) < 85), pick_count());
        end
    endtask

    task automatic test_corner_cases();
        tda_pkg::hms_t zero;
        tda_pkg::hms_t last;
        zero = make_time(0, 0, 0);
        last = make_time(23, 59, 59);
        idle_pct = 19;
        send_item(tda_pkg::OP_VALIDATE, zero, zero, 17'd0);
        send_item(tda_pkg::OP_VALIDATE, last, zero, 17'd0);
        send_item(tda_pkg::OP_VALIDATE, make_time(24, 0, 0), zero, 17'd0);
        send_item(tda_pkg::OP_VALIDATE, make_time(63, 63, 63), zero, 17'd0);
        // wrap past midnight in both directions
        send_item(tda_pkg::OP_NEXT_SEC, last, zero, 17'd0);
        send_item(tda_pkg::OP_PREV_SEC, zero, last, 17'd0);
        send_item(tda_pkg::OP_NEXT_SEC, make_time(0, 59, 59), zero, 17'd0);
        send_item(tda_pkg::OP_ADD, last, last, 17'd0);
        send_item(tda_pkg::OP_ADD, make_time(12, 30, 30), make_time(11, 29, 30), 17'd0);
        send_item(tda_pkg::OP_ADD, last, make_time(0, 60, 0), 17'd0);
        send_item(tda_pkg::OP_DIFF, make_time(10, 0, 1), make_time(9, 0, 0), 17'd0);
        send_item(tda_pkg::OP_DIFF, zero, last, 17'd0);
        // lexicographic order: hour outranks minute and second
        send_item(tda_pkg::OP_COMPARE, make_time(1, 0, 0), make_time(0, 59, 59), 17'd0);
        send_item(tda_pkg::OP_COMPARE, make_time(13, 14, 15), make_time(13, 14, 15),
                  17'd0);
        send_item(tda_pkg::OP_COMPARE, make_time(0, 59, 59), make_time(1, 0, 0), 17'd0);
        send_item(tda_pkg::OP_DURATION, last, zero, 17'd0);
        send_item(tda_pkg::OP_DURATION, zero, last, 17'd0);
        send_item(tda_pkg::OP_TO_SECS, last, zero, 17'd0);
        send_item(tda_pkg::OP_FROM_SECS, zero, zero, 17'(N_LAST_VALID));
        send_item(tda_pkg::OP_FROM_SECS, zero, zero, 17'(DAY_LEN));
        send_item(tda_pkg::OP_FROM_SECS, last, last, 17'(N_FIELD_MAX));
        send_item(tda_pkg::OP_ADD_N, last, zero, 17'(N_LAST_VALID));
        send_item(tda_pkg::OP_SUB_N, zero, zero, 17'(N_LAST_VALID));
        send_item(OP_FIRST_UNUSED, last, last, 17'd1);
        send_item(OP_LAST_UNUSED, zero, zero, 17'd0);
    endtask

    task automatic test_sparse_sender_gaps();
        idle_pct = 19;
        run_random_items(RANDOM_ITEMS);
    endtask

    task automatic test_dense_sender_gaps();
        idle_pct = 81;
        run_random_items(RANDOM_ITEMS);
    endtask

    task automatic test_back_to_back();
        idle_pct = 0;
        run_random_items(RANDOM_ITEMS);
    endtask

    initial
    begin
        error_count     = 0;
        items_sent      = 0;
        results_checked = 0;
        cycle_count     = 0;
        idle_pct        = 0;
        rst_n     <= 1'b0;
        start     <= 1'b0;
        opcode    <= tda_pkg::OP_VALIDATE;
        a_hour    <= '0;
        a_minute  <= '0;
        a_second  <= '0;
        b_hour    <= '0;
        b_minute  <= '0;
        b_second  <= '0;
        n_seconds <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_corner_cases();
        test_sparse_sender_gaps();
        test_dense_sender_gaps();
        test_back_to_back();

        start <= 1'b0;
        while (expected_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d beats over all opcodes, unused codes and bad operands",
                 items_sent);
        $display("%0d results checked under sparse, dense and no sender gaps, %0d errors",
                 results_checked, error_count);
        if (error_count == 0)
        begin
            $display("time_of_day_arithmetic_unit: match");
        end
        else
        begin
            $display("time_of_day_arithmetic_unit: mismatch");
        end
        $finish;
    end

endmodule
